// ===== hw/rtl/krta_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed rating table package
// Shared types and constants for the keyed rating table with item average:
// request and response structures, operation and status codes, slot layout
// and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package krta_pkg;

  // Default number of table slots.
  localparam int unsigned DefCapacity = 64;

  // Width of a key and of a Q8.8 rating.
  localparam int unsigned KeyW    = 16;
  localparam int unsigned RatingW = 16;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_AVERAGE = 2'd3
  } op_e;

  // Status codes carried by a response.
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_FOUND     = 3'd5,
    ST_AVERAGE   = 3'd6
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_APPLY
  } state_e;

  // One input request.
  typedef struct packed {
    op_e                        op;
    logic [KeyW-1:0]            user_key;
    logic [KeyW-1:0]            item_key;
    logic signed [RatingW-1:0]  new_rating;
  } req_t;

  // One response.
  typedef struct packed {
    status_e                    status;
    logic signed [RatingW-1:0]  value;
  } rsp_t;

  // One table slot as held in the slot memory.
  typedef struct packed {
    logic                       valid;
    logic [KeyW-1:0]            user_key;
    logic [KeyW-1:0]            item_key;
    logic [RatingW-1:0]         rating;
  } slot_t;

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_rating_table_with_average_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed rating table with item average
// After reset a clearing pass writes every slot as empty; requests are stalled.
// The scan issues one slot memory read per cycle; averages with a matching
// rating add 16+clog2(CAPACITY+1) divider steps, and S_APPLY holds the response
// while the output register is still held by the receiver.
// One request at a time; the next is taken once the response is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_rating_table_with_average_unit
  import krta_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  input  wire  req_t in_req_i,
  output logic       out_valid_o,
  input  wire  logic out_stall_i,
  output rsp_t       out_rsp_o
);

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = RatingW + CNT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0]  CntCap  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CntLast = CNT_W'(CAPACITY - 1);
  localparam logic [DCNT_W-1:0] DivLast = DCNT_W'(SUM_W - 1);

  // Slot memory: one write and one registered read per cycle.
  slot_t             slot_mem_q [CAPACITY];
  slot_t             rd_data_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_data;
  logic [IDX_W-1:0]  rd_addr;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [RatingW-1:0] hit_rating_q, hit_rating_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  quot_q, quot_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              in_accept;
  logic              out_free;
  logic              scan_done;
  logic              key_match;
  logic              item_match;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic [RatingW-1:0] avg_value;

  // Handshake.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Scan comparisons on the slot read back from memory.
  assign key_match  = rd_data_q.valid && (rd_data_q.user_key == req_q.user_key) &&
                      (rd_data_q.item_key == req_q.item_key);
  assign item_match = rd_data_q.valid && (rd_data_q.item_key == req_q.item_key);
  assign scan_done  = (cnt_q == CntCap) && !rd_pend_q;
  assign rd_addr    = cnt_q[IDX_W-1:0];

  // Divider subtractor: one quotient bit per cycle.
  assign rem_sh  = {rem_q, quot_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, count_q};

  // Signed average from the quotient magnitude.
  assign avg_value = (count_q == '0) ? '0 :
                     (neg_q ? (RatingW'(0) - quot_q[RatingW-1:0]) : quot_q[RatingW-1:0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == CntLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if ((req_q.op == OP_AVERAGE) && (count_q != '0)) begin
            state_d = S_DIV;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_DIV: begin
        if (div_cnt_q == DivLast) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    req_d        = req_q;
    cnt_d        = cnt_q;
    rd_pend_d    = rd_pend_q;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_rating_d = hit_rating_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    sum_d        = sum_q;
    count_d      = count_q;
    quot_d       = quot_q;
    rem_d        = rem_q;
    neg_d        = neg_q;
    div_cnt_d    = div_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rsp_d        = rsp_q;
    wr_en        = 1'b0;
    wr_addr      = cnt_q[IDX_W-1:0];
    wr_data      = '0;

    case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
      end
      S_IDLE: begin
        if (in_accept) begin
          req_d        = in_req_i;
          cnt_d        = '0;
          rd_pend_d    = 1'b0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          sum_d        = '0;
          count_d      = '0;
        end
      end
      S_SCAN: begin
        // Issue the next slot read.
        if (cnt_q < CntCap) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + CNT_W'(1);
        end else begin
          rd_pend_d = 1'b0;
        end
        // Evaluate the slot read in the previous cycle.
        if (rd_pend_q) begin
          if (key_match) begin
            hit_d        = 1'b1;
            hit_idx_d    = rd_idx_q;
            hit_rating_d = rd_data_q.rating;
          end
          if (!rd_data_q.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
          if (item_match) begin
            sum_d   = sum_q + {{(SUM_W-RatingW){rd_data_q.rating[RatingW-1]}},
                               rd_data_q.rating};
            count_d = count_q + CNT_W'(1);
          end
        end
        // Load the divider with the magnitude of the sum.
        if (scan_done) begin
          neg_d     = sum_q[SUM_W-1];
          quot_d    = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
          rem_d     = '0;
          div_cnt_d = '0;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, count_q}) begin
          rem_d  = rem_sub[CNT_W-1:0];
          quot_d = {quot_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[CNT_W-1:0];
          quot_d = {quot_q[SUM_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DCNT_W'(1);
      end
      S_APPLY: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          rsp_d.value  = '0;
          rsp_d.status = ST_NOT_FOUND;
          case (req_q.op)
            OP_INSERT: begin
              wr_data.valid    = 1'b1;
              wr_data.user_key = req_q.user_key;
              wr_data.item_key = req_q.item_key;
              wr_data.rating   = req_q.new_rating;
              if (hit_q) begin
                wr_en        = 1'b1;
                wr_addr      = hit_idx_q;
                rsp_d.status = ST_UPDATED;
              end else if (free_found_q) begin
                wr_en        = 1'b1;
                wr_addr      = free_idx_q;
                rsp_d.status = ST_ADDED;
              end else begin
                rsp_d.status = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (hit_q) begin
                wr_en        = 1'b1;
                wr_addr      = hit_idx_q;
                rsp_d.status = ST_REMOVED;
              end
            end
            OP_LOOKUP: begin
              if (hit_q) begin
                rsp_d.status = ST_FOUND;
                rsp_d.value  = hit_rating_q;
              end
            end
            OP_AVERAGE: begin
              rsp_d.status = ST_AVERAGE;
              rsp_d.value  = avg_value;
            end
            default: begin
              rsp_d.status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // Slot memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= slot_mem_q[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rd_idx_q     <= rd_idx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    hit_rating_q <= hit_rating_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    sum_q        <= sum_d;
    count_q      <= count_d;
    quot_q       <= quot_d;
    rem_q        <= rem_d;
    neg_q        <= neg_d;
    div_cnt_q    <= div_cnt_d;
    rsp_q        <= rsp_d;
  end

  // A key pair must never be present in two slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rd_pend_q && hit_q) |-> !key_match)
    else $error("key pair found in more than one slot");

  // An accepted request always starts a table scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("accepted request did not start a scan");

  // The average magnitude always fits the Q8.8 range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && req_q.op == OP_AVERAGE) |-> (quot_q[SUM_W-1:RatingW] == '0))
    else $error("average quotient out of range");

  // A response is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY && !out_free) |=> (state_q == S_APPLY))
    else $error("response issued while output register busy");

endmodule

`default_nettype wire
